// ----- hw/rtl/mwo_pkg.sv -----
// Shared types, constants, command codes and the CORDIC angle table of the odometry block.
package mwo_pkg;

	localparam int COUNT_WIDTH_DEF = 32;
	localparam int TRIG_STAGES_DEF = 24;

	localparam logic [31:0] DIST_PER_TICK_RST = 32'd674653;
	localparam logic [31:0] TURN_PER_TICK_RST = 32'd306785;
	localparam logic [31:0] INV_GAIN          = 32'h9B74_EDA8;
	localparam logic [31:0] TWO_PI_Q16        = 32'd411775;
	localparam logic [31:0] US_PER_S          = 32'd1000000;

	// register indexes on the configuration port
	localparam logic REG_DIST_PER_TICK = 1'b0;
	localparam logic REG_TURN_PER_TICK = 1'b1;

	// datapath operation codes
	localparam logic [4:0] OP_NONE  = 5'd0;
	localparam logic [4:0] OP_FIRST = 5'd1;
	localparam logic [4:0] OP_MIX   = 5'd2;
	localparam logic [4:0] OP_HMUL  = 5'd3;
	localparam logic [4:0] OP_HEND  = 5'd4;
	localparam logic [4:0] OP_MLO   = 5'd5;
	localparam logic [4:0] OP_MHI   = 5'd6;
	localparam logic [4:0] OP_MEND  = 5'd7;
	localparam logic [4:0] OP_CINIT = 5'd8;
	localparam logic [4:0] OP_CSTEP = 5'd9;
	localparam logic [4:0] OP_CFIN  = 5'd10;
	localparam logic [4:0] OP_POS   = 5'd11;
	localparam logic [4:0] OP_VSET  = 5'd12;
	localparam logic [4:0] OP_VINIT = 5'd13;
	localparam logic [4:0] OP_VDIV  = 5'd14;
	localparam logic [4:0] OP_VEND  = 5'd15;
	localparam logic [4:0] OP_OUT   = 5'd16;

	// destinations of a scaled product
	localparam logic [2:0] SEL_FWD  = 3'd0;
	localparam logic [2:0] SEL_SIDE = 3'd1;
	localparam logic [2:0] SEL_X    = 3'd2;
	localparam logic [2:0] SEL_Y    = 3'd3;
	localparam logic [2:0] SEL_ANG  = 3'd4;

	typedef struct packed {
		logic       load;
		logic [4:0] op;
		logic [2:0] sel;
		logic [4:0] iter;
	} cmd_t;

	typedef struct packed {
		logic dt_zero;
	} status_t;

	function automatic logic [31:0] atan_entry(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0: r = 32'h20000000;
			5'd1: r = 32'h12E4051E;
			5'd2: r = 32'h09FB385B;
			5'd3: r = 32'h051111D4;
			5'd4: r = 32'h028B0D43;
			5'd5: r = 32'h0145D7E1;
			5'd6: r = 32'h00A2F61E;
			5'd7: r = 32'h00517C55;
			5'd8: r = 32'h0028BE53;
			5'd9: r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			5'd24: r = 32'h00000029;
			5'd25: r = 32'h00000014;
			5'd26: r = 32'h0000000A;
			5'd27: r = 32'h00000005;
			5'd28: r = 32'h00000003;
			5'd29: r = 32'h00000001;
			5'd30: r = 32'h00000001;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/mwo_if.sv -----
// Valid/ready channel interfaces for encoder samples and pose results.
interface mwo_sample_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] count_front_left;
	logic signed [31:0] count_front_right;
	logic signed [31:0] count_rear_left;
	logic signed [31:0] count_rear_right;
	logic        [31:0] stamp_us;

	modport source (output valid, count_front_left, count_front_right, count_rear_left,
		count_rear_right, stamp_us, input ready);
	modport sink (input valid, count_front_left, count_front_right, count_rear_left,
		count_rear_right, stamp_us, output ready);
endinterface

interface mwo_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic        [31:0] heading;
	logic signed [31:0] vel_forward;
	logic signed [31:0] vel_side;
	logic signed [31:0] turn_rate;
	logic               zero_interval;

	modport source (output valid, pos_x, pos_y, heading, vel_forward, vel_side, turn_rate,
		zero_interval, input ready);
	modport sink (input valid, pos_x, pos_y, heading, vel_forward, vel_side, turn_rate,
		zero_interval, output ready);
endinterface

// ----- hw/rtl/mwo_ctrl.sv -----
// Sequencer of the odometry block: issues one datapath command per cycle unless the output stalls.
module mwo_ctrl #(
	parameter int TRIG_STAGES = mwo_pkg::TRIG_STAGES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  mwo_pkg::status_t status,
	output mwo_pkg::cmd_t    cmd
);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_FIRST = 5'd1;
	localparam logic [4:0] ST_MIX   = 5'd2;
	localparam logic [4:0] ST_HMUL  = 5'd3;
	localparam logic [4:0] ST_HEND  = 5'd4;
	localparam logic [4:0] ST_MLO   = 5'd5;
	localparam logic [4:0] ST_MHI   = 5'd6;
	localparam logic [4:0] ST_MEND  = 5'd7;
	localparam logic [4:0] ST_CINIT = 5'd8;
	localparam logic [4:0] ST_CSTEP = 5'd9;
	localparam logic [4:0] ST_CFIN  = 5'd10;
	localparam logic [4:0] ST_POS   = 5'd11;
	localparam logic [4:0] ST_VSET  = 5'd12;
	localparam logic [4:0] ST_VLO   = 5'd13;
	localparam logic [4:0] ST_VHI   = 5'd14;
	localparam logic [4:0] ST_VINIT = 5'd15;
	localparam logic [4:0] ST_VDIV  = 5'd16;
	localparam logic [4:0] ST_VEND  = 5'd17;
	localparam logic [4:0] ST_OUT   = 5'd18;

	localparam logic [4:0] CORDIC_LAST = 5'(TRIG_STAGES - 1);
	localparam logic [4:0] DIV_LAST    = 5'd31;

	logic [4:0] state_q, state_d;
	logic [4:0] it_q, it_d;
	logic [2:0] sel_q, sel_d;
	logic       started_q;
	logic       out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d  = state_q;
		it_d     = it_q;
		sel_d    = sel_q;
		cmd      = '0;
		cmd.sel  = sel_q;
		cmd.iter = it_q;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = started_q ? ST_MIX : ST_FIRST;
				end
			end
			ST_FIRST: begin
				cmd.op  = mwo_pkg::OP_FIRST;
				state_d = ST_IDLE;
			end
			ST_MIX: begin
				cmd.op  = mwo_pkg::OP_MIX;
				state_d = ST_HMUL;
			end
			ST_HMUL: begin
				cmd.op  = mwo_pkg::OP_HMUL;
				state_d = ST_HEND;
			end
			ST_HEND: begin
				cmd.op  = mwo_pkg::OP_HEND;
				sel_d   = mwo_pkg::SEL_FWD;
				state_d = ST_MLO;
			end
			ST_MLO: begin
				cmd.op  = mwo_pkg::OP_MLO;
				state_d = ST_MHI;
			end
			ST_MHI: begin
				cmd.op  = mwo_pkg::OP_MHI;
				state_d = ST_MEND;
			end
			ST_MEND: begin
				cmd.op = mwo_pkg::OP_MEND;
				case (sel_q)
					mwo_pkg::SEL_FWD: begin
						sel_d   = mwo_pkg::SEL_SIDE;
						state_d = ST_MLO;
					end
					mwo_pkg::SEL_SIDE: state_d = ST_CINIT;
					mwo_pkg::SEL_X: begin
						sel_d   = mwo_pkg::SEL_Y;
						state_d = ST_MLO;
					end
					mwo_pkg::SEL_Y: state_d = ST_POS;
					default: begin
						sel_d   = mwo_pkg::SEL_FWD;
						state_d = ST_VSET;
					end
				endcase
			end
			ST_CINIT: begin
				cmd.op  = mwo_pkg::OP_CINIT;
				it_d    = '0;
				state_d = ST_CSTEP;
			end
			ST_CSTEP: begin
				cmd.op = mwo_pkg::OP_CSTEP;
				if (it_q == CORDIC_LAST) begin
					state_d = ST_CFIN;
				end else begin
					it_d = it_q + 5'd1;
				end
			end
			ST_CFIN: begin
				cmd.op  = mwo_pkg::OP_CFIN;
				sel_d   = mwo_pkg::SEL_X;
				state_d = ST_MLO;
			end
			ST_POS: begin
				cmd.op = mwo_pkg::OP_POS;
				sel_d  = mwo_pkg::SEL_ANG;
				state_d = status.dt_zero ? ST_OUT : ST_MLO;
			end
			ST_VSET: begin
				cmd.op  = mwo_pkg::OP_VSET;
				state_d = ST_VLO;
			end
			ST_VLO: begin
				cmd.op  = mwo_pkg::OP_MLO;
				state_d = ST_VHI;
			end
			ST_VHI: begin
				cmd.op  = mwo_pkg::OP_MHI;
				state_d = ST_VINIT;
			end
			ST_VINIT: begin
				cmd.op  = mwo_pkg::OP_VINIT;
				it_d    = '0;
				state_d = ST_VDIV;
			end
			ST_VDIV: begin
				cmd.op = mwo_pkg::OP_VDIV;
				if (it_q == DIV_LAST) begin
					state_d = ST_VEND;
				end else begin
					it_d = it_q + 5'd1;
				end
			end
			ST_VEND: begin
				cmd.op = mwo_pkg::OP_VEND;
				if (sel_q == mwo_pkg::SEL_ANG) begin
					state_d = ST_OUT;
				end else begin
					sel_d   = (sel_q == mwo_pkg::SEL_FWD) ? mwo_pkg::SEL_SIDE
						: mwo_pkg::SEL_ANG;
					state_d = ST_VSET;
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op  = mwo_pkg::OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			it_q        <= '0;
			sel_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			it_q    <= it_d;
			sel_q   <= sel_d;
			if (state_q == ST_FIRST) begin
				started_q <= 1'b1;
			end
			// hold the result until the sink takes it
			if (cmd.op == mwo_pkg::OP_OUT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hw/rtl/mwo_datapath.sv -----
// Datapath of the odometry block: mixing, shared multiplier, CORDIC and divider.
module mwo_datapath #(
	parameter int COUNT_WIDTH = mwo_pkg::COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mwo_pkg::cmd_t      cmd,
	output mwo_pkg::status_t   status,
	input  logic        [31:0] dist_per_tick,
	input  logic        [31:0] turn_per_tick,
	input  logic signed [31:0] count_front_left,
	input  logic signed [31:0] count_front_right,
	input  logic signed [31:0] count_rear_left,
	input  logic signed [31:0] count_rear_right,
	input  logic        [31:0] stamp_us,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic        [31:0] heading,
	output logic signed [31:0] vel_forward,
	output logic signed [31:0] vel_side,
	output logic signed [31:0] turn_rate,
	output logic               zero_interval
);

	localparam int CW = COUNT_WIDTH;

	logic        [CW-1:0] prev_q [4];
	logic        [CW-1:0] cur_q  [4];
	logic        [31:0]   prev_stamp_q, stamp_q, dt_q;
	logic signed [31:0]   acc_x_q, acc_y_q;
	logic        [31:0]   acc_head_q, dtheta_q;
	logic signed [34:0]   fwd_q, side_q, turn_q;
	logic        [51:0]   opa_q;
	logic                 sign_q;
	logic        [31:0]   gain_q;
	logic        [63:0]   prod_q, tmp_q;
	logic signed [51:0]   disp_f_q, disp_s_q, dx_q, dy_q, ang_q;
	logic signed [51:0]   cx_q, cy_q;
	logic signed [33:0]   cz_q;
	logic        [31:0]   rem_q, qsh_q;
	logic                 ovf_q;
	logic signed [31:0]   vf_q, vs_q, wr_q;

	logic signed [34:0] dl [4];
	logic signed [34:0] fwd_d, side_d, turn_d;
	logic        [34:0] fmag, smag;
	logic        [31:0] mul_a, mul_b;
	logic        [63:0] prod_d;
	logic        [63:0] mres;
	logic signed [51:0] sres;
	logic               flip;
	logic        [31:0] ang_fold;
	logic signed [51:0] sx, sy;
	logic        [31:0] atan_v;
	logic signed [52:0] sum_x, sum_y;
	logic        [31:0] samag;
	logic signed [51:0] vsrc;
	logic        [40:0] nhi;
	logic        [32:0] rem2;
	logic               ge;
	logic signed [31:0] vres;

	assign status.dt_zero = (dt_q == 32'd0);

	// wrapped count deltas, sign extended
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			logic [CW-1:0] d;
			d     = cur_q[k] - prev_q[k];
			dl[k] = signed'({{(35 - CW){d[CW-1]}}, d});
		end
		fwd_d  = dl[0] + dl[1] + dl[2] + dl[3];
		side_d = dl[1] + dl[2] - dl[0] - dl[3];
		turn_d = dl[1] + dl[3] - dl[0] - dl[2];
	end

	assign fmag = fwd_q[34] ? 35'(-fwd_q) : 35'(fwd_q);
	assign smag = side_q[34] ? 35'(-side_q) : 35'(side_q);

	// shared multiplier
	always_comb begin
		case (cmd.op)
			mwo_pkg::OP_HMUL: begin
				mul_a = turn_q[31:0];
				mul_b = turn_per_tick;
			end
			mwo_pkg::OP_MHI: begin
				mul_a = {12'd0, opa_q[51:32]};
				mul_b = gain_q;
			end
			default: begin
				mul_a = opa_q[31:0];
				mul_b = gain_q;
			end
		endcase
		prod_d = 64'(mul_a) * 64'(mul_b);
	end

	assign mres = {32'd0, tmp_q[63:32]} + prod_q;
	assign sres = sign_q ? -signed'(mres[51:0]) : signed'(mres[51:0]);

	assign flip     = acc_head_q[31] ^ acc_head_q[30];
	assign ang_fold = flip ? acc_head_q + 32'h8000_0000 : acc_head_q;
	assign sx       = cx_q >>> cmd.iter;
	assign sy       = cy_q >>> cmd.iter;
	assign atan_v   = mwo_pkg::atan_entry(cmd.iter);

	assign sum_x = 53'(acc_x_q) + 53'(dx_q);
	assign sum_y = 53'(acc_y_q) + 53'(dy_q);
	assign samag = dtheta_q[31] ? (~dtheta_q + 32'd1) : dtheta_q;

	always_comb begin
		case (cmd.sel)
			mwo_pkg::SEL_FWD:  vsrc = disp_f_q;
			mwo_pkg::SEL_SIDE: vsrc = disp_s_q;
			default: vsrc = ang_q;
		endcase
	end

	assign nhi  = 41'(prod_q) + 41'(tmp_q[63:32]);
	assign rem2 = {rem_q, qsh_q[31]};
	assign ge   = rem2 >= {1'b0, dt_q};

	// saturate the quotient and restore the sign
	always_comb begin
		if (!sign_q) begin
			vres = (ovf_q || qsh_q[31]) ? 32'sh7FFF_FFFF : signed'(qsh_q);
		end else begin
			vres = (ovf_q || (qsh_q[31] && qsh_q[30:0] != 31'd0)) ? 32'sh8000_0000
				: signed'(-qsh_q);
		end
	end

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 4; k++) begin
				prev_q[k] <= '0;
			end
			prev_stamp_q <= '0;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
			acc_head_q   <= '0;
		end else begin
			case (cmd.op)
				mwo_pkg::OP_FIRST, mwo_pkg::OP_MIX: begin
					for (int k = 0; k < 4; k++) begin
						prev_q[k] <= cur_q[k];
					end
					prev_stamp_q <= stamp_q;
				end
				mwo_pkg::OP_HEND: acc_head_q <= acc_head_q + prod_q[31:0];
				mwo_pkg::OP_POS: begin
					acc_x_q <= (sum_x > 53'sh7FFF_FFFF) ? 32'sh7FFF_FFFF
						: (sum_x < -53'sh8000_0000) ? 32'sh8000_0000 : sum_x[31:0];
					acc_y_q <= (sum_y > 53'sh7FFF_FFFF) ? 32'sh7FFF_FFFF
						: (sum_y < -53'sh8000_0000) ? 32'sh8000_0000 : sum_y[31:0];
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q[0] <= count_front_left[CW-1:0];
			cur_q[1] <= count_front_right[CW-1:0];
			cur_q[2] <= count_rear_left[CW-1:0];
			cur_q[3] <= count_rear_right[CW-1:0];
			stamp_q  <= stamp_us;
		end
		case (cmd.op)
			mwo_pkg::OP_MIX: begin
				fwd_q  <= fwd_d;
				side_q <= side_d;
				turn_q <= turn_d;
				dt_q   <= stamp_q - prev_stamp_q;
				vf_q   <= '0;
				vs_q   <= '0;
				wr_q   <= '0;
			end
			mwo_pkg::OP_HMUL: prod_q <= prod_d;
			mwo_pkg::OP_HEND: begin
				dtheta_q <= prod_q[31:0];
				opa_q    <= 52'({fmag, 16'd0});
				sign_q   <= fwd_q[34];
				gain_q   <= dist_per_tick;
			end
			mwo_pkg::OP_MLO: prod_q <= prod_d;
			mwo_pkg::OP_MHI: begin
				tmp_q  <= prod_q;
				prod_q <= prod_d;
			end
			mwo_pkg::OP_MEND: begin
				case (cmd.sel)
					mwo_pkg::SEL_FWD: begin
						disp_f_q <= sres;
						opa_q    <= 52'({smag, 16'd0});
						sign_q   <= side_q[34];
					end
					mwo_pkg::SEL_SIDE: disp_s_q <= sres;
					mwo_pkg::SEL_X: begin
						dx_q   <= sres;
						opa_q  <= cy_q[51] ? 52'(-cy_q) : 52'(cy_q);
						sign_q <= cy_q[51];
					end
					mwo_pkg::SEL_Y: dy_q <= sres;
					default: ang_q <= sres;
				endcase
			end
			mwo_pkg::OP_CINIT: begin
				// fold the angle into [-pi/2, pi/2)
				cx_q <= flip ? -disp_f_q : disp_f_q;
				cy_q <= flip ? -disp_s_q : disp_s_q;
				cz_q <= 34'(signed'(ang_fold));
			end
			mwo_pkg::OP_CSTEP: begin
				if (!cz_q[33]) begin
					cx_q <= cx_q - sy;
					cy_q <= cy_q + sx;
					cz_q <= cz_q - signed'(34'(atan_v));
				end else begin
					cx_q <= cx_q + sy;
					cy_q <= cy_q - sx;
					cz_q <= cz_q + signed'(34'(atan_v));
				end
			end
			mwo_pkg::OP_CFIN: begin
				opa_q  <= cx_q[51] ? 52'(-cx_q) : 52'(cx_q);
				sign_q <= cx_q[51];
				gain_q <= mwo_pkg::INV_GAIN;
			end
			mwo_pkg::OP_POS: begin
				opa_q  <= {20'd0, samag};
				sign_q <= dtheta_q[31];
				gain_q <= mwo_pkg::TWO_PI_Q16;
			end
			mwo_pkg::OP_VSET: begin
				opa_q  <= vsrc[51] ? 52'(-vsrc) : 52'(vsrc);
				sign_q <= vsrc[51];
				gain_q <= mwo_pkg::US_PER_S;
			end
			mwo_pkg::OP_VINIT: begin
				ovf_q <= nhi >= {9'd0, dt_q};
				rem_q <= nhi[31:0];
				qsh_q <= tmp_q[31:0];
			end
			mwo_pkg::OP_VDIV: begin
				rem_q <= ge ? 32'(rem2 - {1'b0, dt_q}) : rem2[31:0];
				qsh_q <= {qsh_q[30:0], ge};
			end
			mwo_pkg::OP_VEND: begin
				case (cmd.sel)
					mwo_pkg::SEL_FWD:  vf_q <= vres;
					mwo_pkg::SEL_SIDE: vs_q <= vres;
					default: wr_q <= vres;
				endcase
			end
			mwo_pkg::OP_OUT: begin
				pos_x         <= acc_x_q;
				pos_y         <= acc_y_q;
				heading       <= acc_head_q;
				vel_forward   <= vf_q;
				vel_side      <= vs_q;
				turn_rate     <= wr_q;
				zero_interval <= (dt_q == 32'd0);
			end
			default: ;
		endcase
	end

endmodule

// ----- hw/rtl/mecanum_wheel_odometry.sv -----
// Top level of the mecanum wheel odometry block: register port, sequencer and datapath.
//
// Each transfer on the sample channel carries four absolute wheel counts and a
// microsecond stamp. The first transfer after reset only latches them and gives no
// result; every later one yields one pose transfer holding x, y (Q16.16 m,
// saturating), heading (2^32 per turn) and robot-frame velocities. One sample at a
// time is processed: the count mix, the heading product, two displacement products,
// TRIG_STAGES CORDIC rotations (24 by default), two rotated products and the position
// update, then the angle product and for each velocity a product and a divide (all
// skipped on a zero interval), on the shared 32x32 multiplier, a CORDIC that rotates
// one stage a cycle and a radix-2 divider forming one quotient bit a cycle. The sample
// channel is ready only when the sequencer is idle; a finished result waits in the
// output register while the next sample is taken. Write distance_per_tick at byte
// address 0 and turn_per_tick at address 4 while no sample is in flight.
module mecanum_wheel_odometry #(
	parameter int COUNT_WIDTH = mwo_pkg::COUNT_WIDTH_DEF,
	parameter int TRIG_STAGES = mwo_pkg::TRIG_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	mwo_sample_if.sink  sample,
	mwo_pose_if.source  pose
);

	logic [31:0]      dist_per_tick_q;
	logic [31:0]      turn_per_tick_q;
	mwo_pkg::cmd_t    cmd;
	mwo_pkg::status_t status;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == mwo_pkg::REG_TURN_PER_TICK) ? turn_per_tick_q
		: dist_per_tick_q;

	// write at the access phase of a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_per_tick_q <= mwo_pkg::DIST_PER_TICK_RST;
			turn_per_tick_q <= mwo_pkg::TURN_PER_TICK_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == mwo_pkg::REG_TURN_PER_TICK) begin
				turn_per_tick_q <= pwdata;
			end else begin
				dist_per_tick_q <= pwdata;
			end
		end
	end

	mwo_ctrl #(
		.TRIG_STAGES(TRIG_STAGES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (sample.ready),
		.out_valid(pose.valid),
		.out_ready(pose.ready),
		.status   (status),
		.cmd      (cmd)
	);

	mwo_datapath #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.dist_per_tick    (dist_per_tick_q),
		.turn_per_tick    (turn_per_tick_q),
		.count_front_left (sample.count_front_left),
		.count_front_right(sample.count_front_right),
		.count_rear_left  (sample.count_rear_left),
		.count_rear_right (sample.count_rear_right),
		.stamp_us         (sample.stamp_us),
		.pos_x            (pose.pos_x),
		.pos_y            (pose.pos_y),
		.heading          (pose.heading),
		.vel_forward      (pose.vel_forward),
		.vel_side         (pose.vel_side),
		.turn_rate        (pose.turn_rate),
		.zero_interval    (pose.zero_interval)
	);

endmodule

// ----- dv/mecanum_wheel_odometry_test.sv -----
// Self-checking testbench for the mecanum wheel odometry block: pose prediction and scoreboard.
module mecanum_wheel_odometry_test;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE      = 220;   // a little over one full sample of work
	localparam int RAND_ITEMS  = 165;   // per register setting

	// CORDIC angles, atan(2^-i) in units of 2^-32 revolution
	localparam bit [31:0] ARCTAN [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
		32'h00000001, 32'h00000000
	};

	typedef struct {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic        [31:0] heading;
		logic signed [31:0] vel_forward;
		logic signed [31:0] vel_side;
		logic signed [31:0] turn_rate;
		logic               zero_interval;
	} pose_t;

	// Pose predictor and store of poses still owed by the block
	class odometry_scoreboard;
		bit [31:0] dist_gain = mwo_pkg::DIST_PER_TICK_RST;
		bit [31:0] turn_gain = mwo_pkg::TURN_PER_TICK_RST;
		bit [31:0] last_count [4];
		bit [31:0] last_stamp;
		bit        latched;
		longint    sum_x, sum_y;
		bit [31:0] sum_heading;
		pose_t     owed [$];
		int        errors;

		function bit [63:0] hi_mul(bit [63:0] a, bit [31:0] g);
			return (a >> 32) * g + (((a & 64'hFFFF_FFFF) * g) >> 32);
		endfunction

		function bit [63:0] mag(longint v);
			return v < 0 ? bit'(64'd0) - v : v;
		endfunction

		// truncates toward zero
		function longint signed_hi_mul(longint v, bit [31:0] g);
			longint r;
			r = longint'(hi_mul(mag(v), g));
			return v < 0 ? -r : r;
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint per_second(longint d, bit [31:0] dt);
			bit [63:0] a, q, r;
			longint    m;
			a = mag(d);
			q = a / {32'd0, dt};
			r = a % {32'd0, dt};
			if (q >= 64'd2148)
				m = 64'sd1 << 40;
			else
				m = longint'(q * 64'd1000000 + (r * 64'd1000000) / {32'd0, dt});
			return clamp32(d < 0 ? -m : m);
		endfunction

		// rotate (x, y) by the heading: fold by half a turn, then CORDIC
		function void rotate(inout longint x, inout longint y, input bit [31:0] ang);
			longint z, t;
			if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
				x = -x;
				y = -y;
				ang += 32'h8000_0000;
			end
			z = longint'($signed(ang));
			for (int i = 0; i < mwo_pkg::TRIG_STAGES_DEF && i < 32; i++) begin
				if (z >= 0) begin
					t = x - (y >>> i);
					y = y + (x >>> i);
					z -= longint'({32'd0, ARCTAN[i]});
				end else begin
					t = x + (y >>> i);
					y = y - (x >>> i);
					z += longint'({32'd0, ARCTAN[i]});
				end
				x = t;
			end
			x = signed_hi_mul(x, mwo_pkg::INV_GAIN);
			y = signed_hi_mul(y, mwo_pkg::INV_GAIN);
		endfunction

		function void note_sample(bit [31:0] cnt [4], bit [31:0] stamp);
			longint    d [4];
			longint    fwd, side, turn, dx, dy, sa, ang;
			bit [63:0] prod;
			bit [31:0] dtheta, dt;
			pose_t     p;
			if (!latched) begin
				latched    = 1;
				last_count = cnt;
				last_stamp = stamp;
				return;
			end
			for (int k = 0; k < 4; k++)
				d[k] = longint'($signed(cnt[k] - last_count[k]));
			fwd  =  d[0] + d[1] + d[2] + d[3];
			side = -d[0] + d[1] + d[2] - d[3];
			turn = -d[0] + d[1] - d[2] + d[3];
			fwd  = signed_hi_mul(fwd * 65536, dist_gain);
			side = signed_hi_mul(side * 65536, dist_gain);
			prod = turn * longint'({32'd0, turn_gain});
			dtheta = prod[31:0];
			sum_heading += dtheta;
			dx = fwd;
			dy = side;
			rotate(dx, dy, sum_heading);
			sum_x = clamp32(sum_x + dx);
			sum_y = clamp32(sum_y + dy);
			dt = stamp - last_stamp;
			p.pos_x = sum_x[31:0];
			p.pos_y = sum_y[31:0];
			p.heading = sum_heading;
			p.vel_forward = '0;
			p.vel_side = '0;
			p.turn_rate = '0;
			p.zero_interval = (dt == 0);
			if (dt != 0) begin
				sa  = longint'($signed(dtheta));
				ang = longint'(hi_mul(mag(sa), mwo_pkg::TWO_PI_Q16));
				if (sa < 0)
					ang = -ang;
				p.vel_forward = 32'(per_second(fwd, dt));
				p.vel_side    = 32'(per_second(side, dt));
				p.turn_rate   = 32'(per_second(ang, dt));
			end
			last_count = cnt;
			last_stamp = stamp;
			owed.push_back(p);
		endfunction

		function void check_pose(pose_t got);
			pose_t want;
			if (owed.size() == 0) begin
				$error("pose transfer with none outstanding");
				errors++;
				return;
			end
			want = owed.pop_front();
			if (got.pos_x !== want.pos_x) begin
				$error("pos_x expected %0d got %0d", want.pos_x, got.pos_x); errors++;
			end
			if (got.pos_y !== want.pos_y) begin
				$error("pos_y expected %0d got %0d", want.pos_y, got.pos_y); errors++;
			end
			if (got.heading !== want.heading) begin
				$error("heading expected %0h got %0h", want.heading, got.heading); errors++;
			end
			if (got.vel_forward !== want.vel_forward) begin
				$error("vel_forward expected %0d got %0d", want.vel_forward, got.vel_forward);
				errors++;
			end
			if (got.vel_side !== want.vel_side) begin
				$error("vel_side expected %0d got %0d", want.vel_side, got.vel_side); errors++;
			end
			if (got.turn_rate !== want.turn_rate) begin
				$error("turn_rate expected %0d got %0d", want.turn_rate, got.turn_rate); errors++;
			end
			if (got.zero_interval !== want.zero_interval) begin
				$error("zero_interval expected %0b got %0b", want.zero_interval,
					got.zero_interval);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	mwo_sample_if sample ();
	mwo_pose_if   pose ();

	mecanum_wheel_odometry i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.sample  (sample.sink),
		.pose    (pose.source)
	);

	odometry_scoreboard pose_sb = new();

	int        send_idle_pct;   // chance of a gap before a sample
	int        recv_stall_pct;  // chance per cycle of holding pose.ready low
	int        sent;
	int        cycles;
	bit [31:0] drv_count [4];   // counts and stamp of the last sample driven
	bit [31:0] drv_stamp;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop: well beyond the slowest legal run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Note every accepted sample; check every accepted pose; pick the next ready
	always @(posedge clk) begin
		bit [31:0] cnt [4];
		pose_t     got;
		if (arst_n && sample.valid && sample.ready) begin
			cnt[0] = sample.count_front_left;
			cnt[1] = sample.count_front_right;
			cnt[2] = sample.count_rear_left;
			cnt[3] = sample.count_rear_right;
			pose_sb.note_sample(cnt, sample.stamp_us);
		end
		if (arst_n && pose.valid && pose.ready) begin
			got.pos_x         = pose.pos_x;
			got.pos_y         = pose.pos_y;
			got.heading       = pose.heading;
			got.vel_forward   = pose.vel_forward;
			got.vel_side      = pose.vel_side;
			got.turn_rate     = pose.turn_rate;
			got.zero_interval = pose.zero_interval;
			pose_sb.check_pose(got);
		end
		pose.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// Idling pattern, changed every few dozen samples so every phase of the work sees gaps
	function automatic void pick_idling();
		case ((sent / 43) % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
			default: begin send_idle_pct = 6; recv_stall_pct = 6; end
		endcase
	endfunction

	// Drive one sample and hold it until the transfer
	task automatic send_sample(bit [31:0] c0, bit [31:0] c1, bit [31:0] c2, bit [31:0] c3,
			bit [31:0] stamp);
		int gap;
		pick_idling();
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 9) : 0;
		if (gap > 0) begin
			sample.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample.valid             <= 1'b1;
		sample.count_front_left  <= c0;
		sample.count_front_right <= c1;
		sample.count_rear_left   <= c2;
		sample.count_rear_right  <= c3;
		sample.stamp_us          <= stamp;
		drv_count = '{c0, c1, c2, c3};
		drv_stamp = stamp;
		do @(posedge clk); while (!(sample.valid && sample.ready));
		sent++;
	endtask

	// Move each wheel by the given delta and advance the stamp by dt
	task automatic send_step(bit [31:0] d0, bit [31:0] d1, bit [31:0] d2, bit [31:0] d3,
			bit [31:0] dt);
		send_sample(drv_count[0] + d0, drv_count[1] + d1, drv_count[2] + d2,
			drv_count[3] + d3, drv_stamp + dt);
	endtask

	// Mostly plausible motion, some violent jumps, zero and very short intervals and raw noise
	task automatic send_random();
		int        pick;
		bit [31:0] d [4];
		pick = $urandom_range(99);
		if (pick < 70) begin
			foreach (d[k]) d[k] = $urandom_range(2000) - 1000;
			send_step(d[0], d[1], d[2], d[3], $urandom_range(5000, 200));
		end else if (pick < 80) begin
			foreach (d[k]) d[k] = $urandom;
			send_step(d[0], d[1], d[2], d[3], $urandom);
		end else if (pick < 88) begin
			foreach (d[k]) d[k] = $urandom_range(200) - 100;
			send_step(d[0], d[1], d[2], d[3], 32'd0);
		end else if (pick < 94) begin
			foreach (d[k]) d[k] = $urandom_range(100000) - 50000;
			send_step(d[0], d[1], d[2], d[3], $urandom_range(3));
		end else begin
			send_sample($urandom, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	// APB write: setup cycle, then access cycle; the register takes it at the next edge
	task automatic write_reg(logic idx, bit [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == mwo_pkg::REG_DIST_PER_TICK)
			pose_sb.dist_gain = value;
		else
			pose_sb.turn_gain = value;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every owed pose, then let any result-less sample finish
	task automatic drain();
		sample.valid <= 1'b0;
		while (pose_sb.owed.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		bit [31:0] gains [5][2];
		arst_n       = 1'b0;
		cycles       = 0;
		sent         = 0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		sample.valid = 1'b0;
		sample.count_front_left  = '0;
		sample.count_front_right = '0;
		sample.count_rear_left   = '0;
		sample.count_rear_right  = '0;
		sample.stamp_us          = '0;
		pose.ready   = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		gains[0] = '{mwo_pkg::DIST_PER_TICK_RST, mwo_pkg::TURN_PER_TICK_RST};
		gains[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF};
		gains[2] = '{32'd0, 32'd0};
		gains[3] = '{$urandom, $urandom};
		gains[4] = '{32'h8000_0000, 32'h0100_0000};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 5; ph++) begin
			write_reg(mwo_pkg::REG_DIST_PER_TICK, gains[ph][0]);
			write_reg(mwo_pkg::REG_TURN_PER_TICK, gains[ph][1]);
			if (ph == 0) begin
				// first sample only latches; the extremes of the counts go in here
				send_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FF00);
				send_step(0, 0, 0, 0, 32'd1000);                     // standing still, stamp wraps
				send_step(1, 1, 1, 1, 32'd1);                         // pure forward, shortest interval
				send_step(-1, 1, 1, -1, 32'd1000);                    // pure sideways
				send_step(-100, 100, -100, 100, 32'd500);             // pure turn
				send_step(100, -100, 100, -100, 32'd0);               // zero interval
				send_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
					32'hFFFF_FFFF);                                   // largest forward delta
				send_step(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
					32'd1);                                           // most negative delta
				send_step(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
					32'd7);                                           // largest turn
				send_step(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
					32'd3);                                           // largest negative turn
				send_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd2);
				send_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd2);
				send_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0);
				send_sample(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
				send_step(5, 5, 5, 5, 32'd0);
			end
			for (int n = 0; n < RAND_ITEMS; n++)
				send_random();
			drain();
		end

		if (pose_sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
